### design/dhpt_pkg.sv
// Shared constants, types and register codes for the dual Hall pulse tachometer.
package dhpt_pkg;

	// Default values of the top-level parameters.
	localparam int TIME_WIDTH_DEF      = 32;
	localparam int SPEED_FRAC_BITS_DEF = 2;

	// Fixed field widths.
	localparam int SPEED_W = 18;
	localparam int COUNT_W = 32;
	localparam int MINI_W  = 16;
	localparam int PPW_W   = 8;
	localparam int MAG_W   = 8;
	localparam int TOUT_W  = 32;

	// Largest reported speed, and microseconds in one minute.
	localparam logic [SPEED_W-1:0] SPEED_MAX = 18'd262143;
	localparam int US_PER_MIN_W = 26;
	localparam logic [US_PER_MIN_W-1:0] US_PER_MIN = 26'd60000000;

	// Configuration register indexes (byte address bits [3:2]).
	localparam int REG_IDX_W = 2;
	localparam logic [REG_IDX_W-1:0] REG_MIN_INTERVAL = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_PULSES_WIN   = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_MAGNETS      = 2'd2;
	localparam logic [REG_IDX_W-1:0] REG_STALL_TOUT   = 2'd3;

	// Register reset values.
	localparam logic [MINI_W-1:0] MIN_INTERVAL_RST = 16'd1000;
	localparam logic [PPW_W-1:0]  PULSES_WIN_RST   = 8'd4;
	localparam logic [MAG_W-1:0]  MAGNETS_RST      = 8'd1;
	localparam logic [TOUT_W-1:0] STALL_TOUT_RST   = 32'd500000;

	// Configuration seen by every lane.
	typedef struct packed {
		logic [MINI_W-1:0] min_interval;
		logic [PPW_W-1:0]  pulses;
		logic [MAG_W-1:0]  magnets;
		logic [TOUT_W-1:0] timeout;
	} cfg_t;

	// What one lane reports for the current tick.
	typedef struct packed {
		logic [SPEED_W-1:0] speed;
		logic               fresh;
		logic [COUNT_W-1:0] count;
	} lane_res_t;

	// Divider sequencer states.
	typedef enum logic [2:0] {
		DV_IDLE,
		DV_MUL,
		DV_CHK,
		DV_ITER,
		DV_DONE
	} div_state_t;

endpackage

### design/dhpt_in_if.sv
// Handshake channel that carries one microsecond tick with its edge flags.
interface dhpt_in_if;
	logic valid;
	logic ready;
	logic edge_left;
	logic edge_right;

	modport source (output valid, output edge_left, output edge_right, input ready);
	modport sink (input valid, input edge_left, input edge_right, output ready);
endinterface

### design/dhpt_out_if.sv
// Handshake channel that carries the per-tick speed and count results.
interface dhpt_out_if;
	logic        valid;
	logic        ready;
	logic [17:0] speed_left;
	logic [17:0] speed_right;
	logic        fresh_left;
	logic        fresh_right;
	logic [31:0] count_left;
	logic [31:0] count_right;

	modport source (output valid, output speed_left, output speed_right, output fresh_left,
		output fresh_right, output count_left, output count_right, input ready);
	modport sink (input valid, input speed_left, input speed_right, input fresh_left,
		input fresh_right, input count_left, input count_right, output ready);
endinterface

### design/dual_hall_pulse_tachometer.sv
// Top level: APB registers, the two channel lanes and the result merge register.
//
//  channel   dir  handshake       payload
//  tick_in   in   valid/ready     edge_left, edge_right
//  res_out   out  valid/ready     speed_*, fresh_*, count_* (left and right)
//  apb       in   psel/penable    paddr[3:2] selects register, 32-bit data
//
// A tick moves into the result register once both lanes have flagged completion and the
// result register is free or being read. When a window closes on either channel, the lane
// divider steps through its multiply and check setup states, the 18 quotient bits and its
// done state, then the lane registers its completion; a saturated speed skips the bits.
// A new tick is taken once the previous one has moved into the result register, which
// holds while res_out is stalled. Reset (arst_n low) clears all channel state and loads
// register defaults.
module dual_hall_pulse_tachometer #(
	parameter int TIME_WIDTH      = dhpt_pkg::TIME_WIDTH_DEF,
	parameter int SPEED_FRAC_BITS = dhpt_pkg::SPEED_FRAC_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	dhpt_in_if.sink           tick_in,
	dhpt_out_if.source        res_out,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [3:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	dhpt_pkg::cfg_t      cfg_q;
	dhpt_pkg::lane_res_t res_l;
	dhpt_pkg::lane_res_t res_r;

	logic run_q;
	logic dl_q;
	logic dr_q;
	logic ov_q;
	logic done_l;
	logic done_r;
	logic start;
	logic both_done;
	logic load;
	logic [dhpt_pkg::REG_IDX_W-1:0] reg_idx;

	logic [dhpt_pkg::SPEED_W-1:0] speed_l_q, speed_r_q;
	logic                         fresh_l_q, fresh_r_q;
	logic [dhpt_pkg::COUNT_W-1:0] count_l_q, count_r_q;

	assign reg_idx = paddr[3:2];
	assign pready  = 1'b1;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_interval <= dhpt_pkg::MIN_INTERVAL_RST;
			cfg_q.pulses       <= dhpt_pkg::PULSES_WIN_RST;
			cfg_q.magnets      <= dhpt_pkg::MAGNETS_RST;
			cfg_q.timeout      <= dhpt_pkg::STALL_TOUT_RST;
		end else if (psel && penable && pwrite) begin
			unique case (reg_idx)
				dhpt_pkg::REG_MIN_INTERVAL: cfg_q.min_interval <= pwdata[15:0];
				dhpt_pkg::REG_PULSES_WIN:   cfg_q.pulses       <= pwdata[7:0];
				dhpt_pkg::REG_MAGNETS:      cfg_q.magnets      <= pwdata[7:0];
				dhpt_pkg::REG_STALL_TOUT:   cfg_q.timeout      <= pwdata;
				default: begin
				end
			endcase
		end
	end

	// Register read back.
	always_comb begin
		unique case (reg_idx)
			dhpt_pkg::REG_MIN_INTERVAL: prdata = 32'(cfg_q.min_interval);
			dhpt_pkg::REG_PULSES_WIN:   prdata = 32'(cfg_q.pulses);
			dhpt_pkg::REG_MAGNETS:      prdata = 32'(cfg_q.magnets);
			dhpt_pkg::REG_STALL_TOUT:   prdata = cfg_q.timeout;
			default:                    prdata = '0;
		endcase
	end

	// Input transaction starts both lanes at once.
	assign tick_in.ready = !run_q;
	assign start         = tick_in.valid && !run_q;

	dhpt_lane #(
		.TIME_WIDTH      (TIME_WIDTH),
		.SPEED_FRAC_BITS (SPEED_FRAC_BITS)
	) u_lane_l (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.edge_seen (tick_in.edge_left),
		.cfg       (cfg_q),
		.done      (done_l),
		.res       (res_l)
	);

	dhpt_lane #(
		.TIME_WIDTH      (TIME_WIDTH),
		.SPEED_FRAC_BITS (SPEED_FRAC_BITS)
	) u_lane_r (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.edge_seen (tick_in.edge_right),
		.cfg       (cfg_q),
		.done      (done_r),
		.res       (res_r)
	);

	// Merge: wait for both lanes, then move their results into the output register.
	assign both_done = run_q && (dl_q || done_l) && (dr_q || done_r);
	assign load      = both_done && (!ov_q || res_out.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			dl_q  <= 1'b0;
			dr_q  <= 1'b0;
			ov_q  <= 1'b0;
		end else begin
			if (start) begin
				run_q <= 1'b1;
			end else if (load) begin
				run_q <= 1'b0;
			end
			if (load || start) begin
				dl_q <= 1'b0;
				dr_q <= 1'b0;
			end else begin
				if (done_l) dl_q <= 1'b1;
				if (done_r) dr_q <= 1'b1;
			end
			if (load) begin
				ov_q <= 1'b1;
			end else if (res_out.ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			speed_l_q <= res_l.speed;
			speed_r_q <= res_r.speed;
			fresh_l_q <= res_l.fresh;
			fresh_r_q <= res_r.fresh;
			count_l_q <= res_l.count;
			count_r_q <= res_r.count;
		end
	end

	assign res_out.valid       = ov_q;
	assign res_out.speed_left  = speed_l_q;
	assign res_out.speed_right = speed_r_q;
	assign res_out.fresh_left  = fresh_l_q;
	assign res_out.fresh_right = fresh_r_q;
	assign res_out.count_left  = count_l_q;
	assign res_out.count_right = count_r_q;

	// A lane reports completion only for a tick in flight.
	a_done_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		(done_l || done_r) |-> run_q)
		else $error("lane completion without a tick in flight");

	// Each lane completes once per tick.
	a_done_once: assert property (@(posedge clk) disable iff (!arst_n)
		!(dl_q && done_l) && !(dr_q && done_r))
		else $error("lane completed twice for one tick");

	// A merge leaves the result valid and no tick in flight.
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> (ov_q && !run_q))
		else $error("result register not loaded after merge");

endmodule

### design/dhpt_div.sv
// Iterative speed divider: 60e6*N*2^F / (dt*M), one quotient bit per cycle, saturated.
module dhpt_div #(
	parameter int TIME_WIDTH      = dhpt_pkg::TIME_WIDTH_DEF,
	parameter int SPEED_FRAC_BITS = dhpt_pkg::SPEED_FRAC_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [TIME_WIDTH-1:0]         dt,
	input  logic [dhpt_pkg::PPW_W-1:0]    n,
	input  logic [dhpt_pkg::MAG_W-1:0]    m,
	output logic                          done,
	output logic [dhpt_pkg::SPEED_W-1:0]  quot
);

	localparam int QW     = dhpt_pkg::SPEED_W;
	localparam int NUM_W  = dhpt_pkg::US_PER_MIN_W + dhpt_pkg::PPW_W + SPEED_FRAC_BITS;
	localparam int DEN_W  = TIME_WIDTH + dhpt_pkg::MAG_W;
	localparam int CMP_W  = DEN_W + QW;
	localparam int CNT_W  = $clog2(QW);

	dhpt_pkg::div_state_t state_q, state_nxt;

	logic [TIME_WIDTH-1:0]      dt_q;
	logic [dhpt_pkg::PPW_W-1:0] n_q;
	logic [dhpt_pkg::MAG_W-1:0] m_q;
	logic [NUM_W-1:0]           num_q;
	logic [DEN_W-1:0]           den_q;
	logic [NUM_W-1:0]           rem_q;
	logic [CMP_W-1:0]           dsh_q;
	logic [CNT_W-1:0]           cnt_q;
	logic [QW-1:0]              quot_q;
	logic                       sat;
	logic                       ge;

	// Quotient would reach 2^18 or more: report the saturated value.
	assign sat = CMP_W'(num_q) >= (CMP_W'(den_q) << QW);
	// Restoring step: the shifted divisor fits in the remainder.
	assign ge  = CMP_W'(rem_q) >= dsh_q;

	// Next-state logic.
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			dhpt_pkg::DV_IDLE: if (start) state_nxt = dhpt_pkg::DV_MUL;
			dhpt_pkg::DV_MUL:  state_nxt = dhpt_pkg::DV_CHK;
			dhpt_pkg::DV_CHK:  state_nxt = sat ? dhpt_pkg::DV_DONE : dhpt_pkg::DV_ITER;
			dhpt_pkg::DV_ITER: if (cnt_q == '0) state_nxt = dhpt_pkg::DV_DONE;
			dhpt_pkg::DV_DONE: state_nxt = dhpt_pkg::DV_IDLE;
			default:           state_nxt = dhpt_pkg::DV_IDLE;
		endcase
	end

	// Output logic.
	always_comb begin
		done = (state_q == dhpt_pkg::DV_DONE);
		quot = quot_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dhpt_pkg::DV_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Datapath registers, stepped by the sequencer state.
	always_ff @(posedge clk) begin
		case (state_q)
			dhpt_pkg::DV_IDLE: begin
				if (start) begin
					dt_q <= dt;
					n_q  <= n;
					m_q  <= m;
				end
			end
			dhpt_pkg::DV_MUL: begin
				num_q <= (NUM_W'(dhpt_pkg::US_PER_MIN) * NUM_W'(n_q)) << SPEED_FRAC_BITS;
				den_q <= DEN_W'(dt_q) * DEN_W'(m_q);
			end
			dhpt_pkg::DV_CHK: begin
				rem_q  <= num_q;
				dsh_q  <= CMP_W'(den_q) << (QW - 1);
				cnt_q  <= CNT_W'(QW - 1);
				quot_q <= sat ? dhpt_pkg::SPEED_MAX : '0;
			end
			dhpt_pkg::DV_ITER: begin
				if (ge) begin
					rem_q <= rem_q - dsh_q[NUM_W-1:0];
				end
				quot_q <= {quot_q[QW-2:0], ge};
				dsh_q  <= dsh_q >> 1;
				cnt_q  <= cnt_q - 1'b1;
			end
			default: begin
			end
		endcase
	end

endmodule

### design/dhpt_lane.sv
// One tachometer channel: debounce, edge count, window timing and its own divider.
module dhpt_lane #(
	parameter int TIME_WIDTH      = dhpt_pkg::TIME_WIDTH_DEF,
	parameter int SPEED_FRAC_BITS = dhpt_pkg::SPEED_FRAC_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic                edge_seen,
	input  dhpt_pkg::cfg_t      cfg,
	output logic                done,
	output dhpt_pkg::lane_res_t res
);

	localparam int CW = (TIME_WIDTH > dhpt_pkg::TOUT_W) ? TIME_WIDTH : dhpt_pkg::TOUT_W;

	logic [TIME_WIDTH-1:0]        since_q;
	logic [TIME_WIDTH-1:0]        wtime_q;
	logic [dhpt_pkg::PPW_W-1:0]   wedges_q;
	logic                         wopen_q;
	logic [dhpt_pkg::COUNT_W-1:0] total_q;
	logic [dhpt_pkg::SPEED_W-1:0] speed_q;
	logic                         fresh_q;
	logic                         done_q;

	logic [TIME_WIDTH-1:0]      since_inc;
	logic [TIME_WIDTH-1:0]      wtime_inc;
	logic [TIME_WIDTH-1:0]      since_new;
	logic [dhpt_pkg::PPW_W-1:0] edges_inc;
	logic [dhpt_pkg::PPW_W-1:0] n_eff;
	logic [dhpt_pkg::MAG_W-1:0] m_eff;
	logic                       acc;
	logic                       close;
	logic                       stall;
	logic                       div_done;
	logic [dhpt_pkg::SPEED_W-1:0] div_quot;

	// Saturating time counters; the window timer runs only while a window is open.
	always_comb begin
		since_inc = (since_q == '1) ? since_q : since_q + 1'b1;
		if (wopen_q) begin
			wtime_inc = (wtime_q == '1) ? wtime_q : wtime_q + 1'b1;
		end else begin
			wtime_inc = wtime_q;
		end
		n_eff     = (cfg.pulses == '0) ? dhpt_pkg::PPW_W'(1) : cfg.pulses;
		m_eff     = (cfg.magnets == '0) ? dhpt_pkg::MAG_W'(1) : cfg.magnets;
		edges_inc = wedges_q + 1'b1;
		acc       = edge_seen && (since_inc >= TIME_WIDTH'(cfg.min_interval));
		close     = acc && wopen_q && (edges_inc >= n_eff);
		since_new = acc ? '0 : since_inc;
		stall     = CW'(since_new) > CW'(cfg.timeout);
	end

	// Tick update of the channel state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			since_q  <= '0;
			wtime_q  <= '0;
			wedges_q <= '0;
			wopen_q  <= 1'b0;
			total_q  <= '0;
			speed_q  <= '0;
			fresh_q  <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			done_q <= (start && !close) || div_done;
			if (div_done) begin
				speed_q <= div_quot;
			end
			if (start) begin
				since_q <= since_new;
				fresh_q <= close;
				if (acc) begin
					total_q <= total_q + 1'b1;
					if (!wopen_q || close) begin
						wopen_q  <= 1'b1;
						wtime_q  <= '0;
						wedges_q <= '0;
					end else begin
						wedges_q <= edges_inc;
						wtime_q  <= wtime_inc;
					end
				end else begin
					wtime_q <= wtime_inc;
				end
				// A closing window always clears the idle time, so no stall then.
				if (!close && stall) begin
					speed_q <= '0;
				end
			end
		end
	end

	dhpt_div #(
		.TIME_WIDTH      (TIME_WIDTH),
		.SPEED_FRAC_BITS (SPEED_FRAC_BITS)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start && close),
		.dt     (wtime_inc),
		.n      (n_eff),
		.m      (m_eff),
		.done   (div_done),
		.quot   (div_quot)
	);

	assign done      = done_q;
	assign res.speed = speed_q;
	assign res.fresh = fresh_q;
	assign res.count = total_q;

endmodule
